>>> hw/rtl/mch_pkg.sv
// ----------------------------------------------------------------------------
// mch_pkg: shared types and constants for the monotone chain half hull
// Item op codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mch_pkg;

    localparam int TAG_W = 12;
    localparam int OP_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_REFILL,
        ST_READ,
        ST_FIN
    } state_t;

endpackage

>>> hw/rtl/mch_if.sv
// ----------------------------------------------------------------------------
// mch_if: point and result channels of the half hull builder
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mch_pt_if #(
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 10
);
    import mch_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [OP_W-1:0]              op;
    logic signed [COORD_BITS-1:0] pt_x;
    logic signed [COORD_BITS-1:0] pt_y;
    logic [TAG_W-1:0]             pt_tag;
    logic [IDX_W-1:0]             read_index;

    modport source (
        output valid, op, pt_x, pt_y, pt_tag, read_index,
        input  ready
    );
    modport sink (
        input  valid, op, pt_x, pt_y, pt_tag, read_index,
        output ready
    );
endinterface

interface mch_res_if #(
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 10,
    parameter int DEPTH_W    = 11
);
    import mch_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [DEPTH_W-1:0]           hull_depth;
    logic [IDX_W-1:0]             popped_count;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic [TAG_W-1:0]             out_tag;
    logic                         overflow;

    modport source (
        output valid, hull_depth, popped_count, out_x, out_y, out_tag, overflow,
        input  ready
    );
    modport sink (
        input  valid, hull_depth, popped_count, out_x, out_y, out_tag, overflow,
        output ready
    );
endinterface

>>> hw/rtl/mch_orient.sv
// ----------------------------------------------------------------------------
// mch_orient: registered orientation test for three hull points
// Registers the two cross product terms on load and compares them from the registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mch_orient #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic signed [COORD_BITS-1:0] top_x,
    input  logic signed [COORD_BITS-1:0] top_y,
    input  logic signed [COORD_BITS-1:0] sec_x,
    input  logic signed [COORD_BITS-1:0] sec_y,
    input  logic signed [COORD_BITS-1:0] new_x,
    input  logic signed [COORD_BITS-1:0] new_y,
    output logic                         left_turn
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] bx, by, ax, ay;
    logic signed [PW-1:0] lhs_reg, rhs_reg;

    // differences need one extra bit to stay exact
    assign bx = $signed({top_x[COORD_BITS-1], top_x}) - $signed({sec_x[COORD_BITS-1], sec_x});
    assign by = $signed({top_y[COORD_BITS-1], top_y}) - $signed({sec_y[COORD_BITS-1], sec_y});
    assign ax = $signed({new_x[COORD_BITS-1], new_x}) - $signed({top_x[COORD_BITS-1], top_x});
    assign ay = $signed({new_y[COORD_BITS-1], new_y}) - $signed({top_y[COORD_BITS-1], top_y});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lhs_reg <= bx * ay;
            rhs_reg <= by * ax;
        end
    end

    assign left_turn = lhs_reg > rhs_reg;

endmodule

>>> hw/rtl/monotone_chain_half_hull.sv
// ----------------------------------------------------------------------------
// monotone_chain_half_hull: half hull stack with monotone chain pops
// Push: multiply, compare, and for each popped entry a stack memory read to
// refill the second entry before the next multiply; a pop that leaves one
// entry skips the read. Read goes through ST_READ; clear and the unused op through ST_FIN. A held result delays it.
// One item in flight; results wait in an output register.
// Reset empties the stack at once; the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module monotone_chain_half_hull #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    mch_pt_if.sink    pt_ch,
    mch_res_if.source res_ch
);
    import mch_pkg::*;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int DEPTH_W = $clog2(MAX_POINTS + 1);
    localparam int ENTRY_W = 2 * COORD_BITS + TAG_W;
    localparam int X_LSB   = TAG_W + COORD_BITS;
    localparam int Y_LSB   = TAG_W;

    state_t               state_reg, state_next;
    logic [DEPTH_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]     pop_reg, pop_next;
    logic [ENTRY_W-1:0]   top_reg, top_next;
    logic [ENTRY_W-1:0]   sec_reg, sec_next;
    logic [ENTRY_W-1:0]   new_reg, new_next;
    op_t                  op_reg, op_next;
    logic                 hit_reg, hit_next;

    logic                 res_valid_reg, res_valid_next;
    logic [DEPTH_W-1:0]   res_depth_reg, res_depth_next;
    logic [IDX_W-1:0]     res_pop_reg, res_pop_next;
    logic [COORD_BITS-1:0] res_x_reg, res_x_next;
    logic [COORD_BITS-1:0] res_y_reg, res_y_next;
    logic [TAG_W-1:0]     res_tag_reg, res_tag_next;
    logic                 res_ovf_reg, res_ovf_next;
    logic                 res_load;

    logic [ENTRY_W-1:0]   stack_mem [MAX_POINTS];
    logic [ENTRY_W-1:0]   rdata_reg;
    logic                 mem_we, mem_re;
    logic [IDX_W-1:0]     mem_waddr, mem_raddr;

    logic                 out_free;
    logic                 read_hit;
    logic                 left_turn;
    logic                 pop_fire;
    logic [DEPTH_W-1:0]   third_idx;

    assign out_free  = !res_valid_reg || res_ch.ready;
    assign read_hit  = DEPTH_W'(pt_ch.read_index) < count_reg;
    assign third_idx = count_reg - DEPTH_W'(3);

    mch_orient #(
        .COORD_BITS (COORD_BITS)
    ) u_orient (
        .clk       (clk),
        .load      (state_reg == ST_MUL),
        .top_x     ($signed(top_reg[X_LSB +: COORD_BITS])),
        .top_y     ($signed(top_reg[Y_LSB +: COORD_BITS])),
        .sec_x     ($signed(sec_reg[X_LSB +: COORD_BITS])),
        .sec_y     ($signed(sec_reg[Y_LSB +: COORD_BITS])),
        .new_x     ($signed(new_reg[X_LSB +: COORD_BITS])),
        .new_y     ($signed(new_reg[Y_LSB +: COORD_BITS])),
        .left_turn (left_turn)
    );

    // stack memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= new_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= stack_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pop_next       = pop_reg;
        top_next       = top_reg;
        sec_next       = sec_reg;
        new_next       = new_reg;
        op_next        = op_reg;
        hit_next       = hit_reg;
        res_load       = 1'b0;
        res_depth_next = count_reg;
        res_pop_next   = '0;
        res_x_next     = '0;
        res_y_next     = '0;
        res_tag_next   = '0;
        res_ovf_next   = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_raddr      = pt_ch.read_index;
        pop_fire       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pt_ch.valid)
                begin
                    op_next  = op_t'(pt_ch.op);
                    new_next = {pt_ch.pt_x, pt_ch.pt_y, pt_ch.pt_tag};
                    pop_next = '0;
                    hit_next = read_hit;
                    unique case (op_t'(pt_ch.op))
                        OP_PUSH:
                        begin
                            state_next = ST_MUL;
                        end
                        OP_READ:
                        begin
                            mem_re     = read_hit;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (count_reg >= DEPTH_W'(2) && left_turn)
                begin
                    // drop the top; the old second becomes the new top
                    pop_fire   = 1'b1;
                    count_next = count_reg - DEPTH_W'(1);
                    pop_next   = pop_reg + IDX_W'(1);
                    top_next   = sec_reg;
                    if (count_reg >= DEPTH_W'(3))
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = third_idx[IDX_W-1:0];
                        state_next = ST_REFILL;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
                else if (out_free)
                begin
                    res_load     = 1'b1;
                    res_pop_next = pop_reg;
                    if (count_reg == DEPTH_W'(MAX_POINTS))
                    begin
                        res_ovf_next = 1'b1;
                    end
                    else
                    begin
                        mem_we         = 1'b1;
                        count_next     = count_reg + DEPTH_W'(1);
                        res_depth_next = count_reg + DEPTH_W'(1);
                        top_next       = new_reg;
                        sec_next       = top_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_REFILL:
            begin
                sec_next   = rdata_reg;
                state_next = ST_MUL;
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    res_load     = 1'b1;
                    res_ovf_next = !hit_reg;
                    if (hit_reg)
                    begin
                        res_x_next   = rdata_reg[X_LSB +: COORD_BITS];
                        res_y_next   = rdata_reg[Y_LSB +: COORD_BITS];
                        res_tag_next = rdata_reg[TAG_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    if (op_reg == OP_CLEAR)
                    begin
                        count_next     = '0;
                        res_depth_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_reg <= pop_next;
        top_reg <= top_next;
        sec_reg <= sec_next;
        new_reg <= new_next;
        op_reg  <= op_next;
        hit_reg <= hit_next;
        if (res_load)
        begin
            res_depth_reg <= res_depth_next;
            res_pop_reg   <= res_pop_next;
            res_x_reg     <= res_x_next;
            res_y_reg     <= res_y_next;
            res_tag_reg   <= res_tag_next;
            res_ovf_reg   <= res_ovf_next;
        end
    end

    assign pt_ch.ready         = (state_reg == ST_IDLE);
    assign res_ch.valid        = res_valid_reg;
    assign res_ch.hull_depth   = res_depth_reg;
    assign res_ch.popped_count = res_pop_reg;
    assign res_ch.out_x        = $signed(res_x_reg);
    assign res_ch.out_y        = $signed(res_y_reg);
    assign res_ch.out_tag      = res_tag_reg;
    assign res_ch.overflow     = res_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_W'(MAX_POINTS))
        else $error("stack count beyond capacity");

    a_refill_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REFILL) |-> $past(mem_re))
        else $error("refill without a stack memory read");

    a_pop_shift: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire |=> (top_reg == $past(sec_reg)))
        else $error("pop did not promote the second entry");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_ch.valid && pt_ch.ready) |=> !pt_ch.ready)
        else $error("new item taken while one is in progress");

endmodule

>>> tb/monotone_chain_half_hull_tb.sv
// ----------------------------------------------------------------------------
// monotone_chain_half_hull_tb: self-checking bench for the half hull builder
// Feeds push, read and clear items through the point channel and checks each
// result item against a predictor of the pop-while-left-turn hull stack.
// Sorted point runs with random content, collinear and duplicate points, full
// range coordinates, a full stack, reads past the top and random noise;
// random idle bursts on both channels and long output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module monotone_chain_half_hull_tb;
    import mch_pkg::*;

    localparam int MAX_PTS        = 1024;
    localparam int COORD_W        = 16;
    localparam int IDX_W          = 10;
    localparam int DEPTH_W        = 11;
    localparam int RAND_ITEMS     = 950;
    localparam int TAIL_ITEMS     = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 20;

    // op code the block answers with a result and no change to the stack
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [TAG_W-1:0]          tag;
        logic [IDX_W-1:0]          idx;
    } pt_cmd_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]        depth;
        logic [IDX_W-1:0]          popped;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [TAG_W-1:0]          tag;
        logic                      ovf;
    } hull_res_t;

    logic clk;
    logic rst_n;

    mch_pt_if  #(.COORD_BITS(COORD_W), .IDX_W(IDX_W)) pt_ch ();
    mch_res_if #(.COORD_BITS(COORD_W), .IDX_W(IDX_W), .DEPTH_W(DEPTH_W)) res_ch ();

    monotone_chain_half_hull #(
        .MAX_POINTS(MAX_PTS),
        .COORD_BITS(COORD_W)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pt_ch  (pt_ch),
        .res_ch (res_ch)
    );

    // hull stack as the predictor sees it
    logic signed [COORD_W-1:0] hull_xs [MAX_PTS];
    logic signed [COORD_W-1:0] hull_ys [MAX_PTS];
    logic [TAG_W-1:0]          hull_tags [MAX_PTS];
    int                        hull_cnt;

    pt_cmd_t   pend_q [$];
    hull_res_t hull_exp_q [$];

    logic pt_taken;
    int   mismatches;
    int   live_items;
    int   idle_pct;
    int   cyc;
    int   stall_cycles;
    int   src_gap;
    int   sink_gap;
    int   hold_cnt;
    int   press_idx;

    always #5 clk = ~clk;

    function automatic hull_res_t hull_apply(pt_cmd_t c);
        hull_res_t r;
        longint    bx, by, ax, ay;
        int        pops;
        r = '0;
        pops = 0;
        case (c.op)
            OP_PUSH:
            begin
                while (hull_cnt >= 2)
                begin
                    bx = longint'(hull_xs[hull_cnt-1]) - longint'(hull_xs[hull_cnt-2]);
                    by = longint'(hull_ys[hull_cnt-1]) - longint'(hull_ys[hull_cnt-2]);
                    ax = longint'(c.x) - longint'(hull_xs[hull_cnt-1]);
                    ay = longint'(c.y) - longint'(hull_ys[hull_cnt-1]);
                    if (bx * ay > by * ax)
                    begin
                        hull_cnt--;
                        pops++;
                    end
                    else
                        break;
                end
                if (hull_cnt >= MAX_PTS)
                    r.ovf = 1'b1;
                else
                begin
                    hull_xs[hull_cnt]   = c.x;
                    hull_ys[hull_cnt]   = c.y;
                    hull_tags[hull_cnt] = c.tag;
                    hull_cnt++;
                end
            end
            OP_READ:
            begin
                if (int'(c.idx) < hull_cnt)
                begin
                    r.x   = hull_xs[c.idx];
                    r.y   = hull_ys[c.idx];
                    r.tag = hull_tags[c.idx];
                end
                else
                    r.ovf = 1'b1;
            end
            OP_CLEAR:
                hull_cnt = 0;
            default:
                ;
        endcase
        r.depth  = DEPTH_W'(hull_cnt);
        r.popped = IDX_W'(pops);
        return r;
    endfunction

    function automatic void queue_cmd(logic [OP_W-1:0] op, logic [COORD_W-1:0] x,
                                      logic [COORD_W-1:0] y, logic [TAG_W-1:0] tag,
                                      logic [IDX_W-1:0] idx);
        pt_cmd_t c;
        c.op  = op;
        c.x   = x;
        c.y   = y;
        c.tag = tag;
        c.idx = idx;
        pend_q.insert(pend_q.size(), c);
        if (op != OP_UNUSED)
            live_items++;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return IDX_W'($urandom_range(0, 3));
        else if (r < 9)
            return IDX_W'($urandom_range(0, 15));
        return IDX_W'($urandom);
    endfunction

    function automatic bit idle_draw();
        return (pend_q.size() > TAIL_ITEMS) && ($urandom_range(0, 99) < idle_pct);
    endfunction

    task automatic cmp_field(input string fname, input logic [COORD_W-1:0] want,
                             input logic [COORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // stimulus
    initial
    begin
        int                  i;
        int                  n;
        int                  k;
        int                  span;
        int                  target;
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [COORD_W-1:0]  px;
        logic [COORD_W-1:0]  py;
        bit [31:0]           keys [$];

        clk              = 1'b0;
        rst_n            = 1'b0;
        pt_ch.valid      = 1'b0;
        pt_ch.op         = OP_PUSH;
        pt_ch.pt_x       = '0;
        pt_ch.pt_y       = '0;
        pt_ch.pt_tag     = '0;
        pt_ch.read_index = '0;
        res_ch.ready     = 1'b0;
        hull_cnt         = 0;
        mismatches       = 0;
        live_items       = 0;
        idle_pct         = 0;
        src_gap          = 0;
        sink_gap         = 0;
        hold_cnt         = 0;
        press_idx        = 0;

        // directed: empty reads, extreme corners, exact cross at full width
        queue_cmd(OP_READ, 16'h0, 16'h0, 12'h0, 10'd0);
        queue_cmd(OP_UNUSED, 16'h1234, 16'h5678, 12'hABC, 10'h3FF);
        queue_cmd(OP_PUSH, 16'h8000, 16'h8000, 12'h000, 10'h000);
        queue_cmd(OP_PUSH, 16'h8000, 16'h7FFF, 12'hFFF, 10'h3FF);
        queue_cmd(OP_PUSH, 16'h0000, 16'h0000, 12'h555, 10'h000);
        queue_cmd(OP_PUSH, 16'h7FFF, 16'h7FFF, 12'hAAA, 10'h000);
        queue_cmd(OP_PUSH, 16'h7FFF, 16'h8000, 12'h0F0, 10'h000);
        // duplicate point: collinear, kept
        queue_cmd(OP_PUSH, 16'h7FFF, 16'h8000, 12'h00F, 10'h000);
        for (i = 0; i < 6; i++)
            queue_cmd(OP_READ, 16'h0, 16'h0, 12'h0, IDX_W'(i));
        queue_cmd(OP_READ, 16'hFFFF, 16'hFFFF, 12'hFFF, 10'h3FF);
        queue_cmd(OP_UNUSED, 16'hFFFF, 16'hFFFF, 12'hFFF, 10'h000);
        queue_cmd(OP_CLEAR, 16'h0, 16'h0, 12'h0, 10'h0);
        queue_cmd(OP_READ, 16'h0, 16'h0, 12'h0, 10'd0);
        queue_cmd(OP_PUSH, 16'h0001, 16'hFFFF, 12'h800, 10'h200);
        queue_cmd(OP_READ, 16'h0, 16'h0, 12'h0, 10'd0);
        queue_cmd(OP_CLEAR, 16'h0, 16'h0, 12'h0, 10'h0);

        // full stack: collinear run fills every entry, then a drop, then a point
        // above the line that pops all but the bottom entry
        for (i = 0; i < MAX_PTS; i++)
            queue_cmd(OP_PUSH, 16'h8000 + COORD_W'(i * 64), 16'h8000, TAG_W'(i),
                      IDX_W'($urandom));
        queue_cmd(OP_READ, 16'h0, 16'h0, 12'h0, 10'd1023);
        queue_cmd(OP_PUSH, 16'h7FFF, 16'h8000, 12'hFFF, 10'h0);
        queue_cmd(OP_PUSH, 16'h7FFF, 16'h7FFF, 12'h7E7, 10'h0);
        queue_cmd(OP_READ, 16'h0, 16'h0, 12'h0, 10'd1);
        queue_cmd(OP_READ, 16'h0, 16'h0, 12'h0, 10'd2);
        queue_cmd(OP_CLEAR, 16'h0, 16'h0, 12'h0, 10'h0);

        // random: mostly sorted runs, some unsorted noise
        target = live_items + RAND_ITEMS;
        while (live_items < target)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 4) != 0)
                    queue_cmd(OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                              TAG_W'($urandom), IDX_W'($urandom));
                n = $urandom_range(2, 40);
                case ($urandom_range(0, 2))
                    0: span = 8;
                    1: span = 512;
                    default: span = 65535;
                endcase
                cx = COORD_W'($urandom);
                cy = COORD_W'($urandom);
                keys.delete();
                for (i = 0; i < n; i++)
                begin
                    px = cx + COORD_W'($urandom_range(0, span));
                    py = cy + COORD_W'($urandom_range(0, span));
                    // flip sign bits so an unsigned sort orders by x, then y
                    keys.insert(keys.size(), {px ^ 16'h8000, py ^ 16'h8000});
                end
                keys.sort();
                foreach (keys[k])
                begin
                    queue_cmd(OP_PUSH, keys[k][31:16] ^ 16'h8000, keys[k][15:0] ^ 16'h8000,
                              TAG_W'($urandom), IDX_W'($urandom));
                    if ($urandom_range(0, 5) == 0)
                        queue_cmd(OP_READ, COORD_W'($urandom), COORD_W'($urandom),
                                  TAG_W'($urandom), pick_index());
                end
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    queue_cmd(OP_READ, COORD_W'($urandom), COORD_W'($urandom),
                              TAG_W'($urandom), pick_index());
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                begin
                    k = $urandom_range(0, 19);
                    queue_cmd((k < 11) ? OP_PUSH : (k < 17) ? OP_READ :
                              (k < 19) ? OP_CLEAR : OP_UNUSED,
                              COORD_W'($urandom), COORD_W'($urandom),
                              TAG_W'($urandom), pick_index());
                end
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pend_q.size() == 0);
        wait (hull_exp_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // point channel driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pt_taken)
                void'(pend_q.pop_front());
            if (pt_ch.valid && !pt_taken)
            begin
                // hold the offered item until it is taken
            end
            else if (src_gap > 0)
            begin
                src_gap--;
                pt_ch.valid <= 1'b0;
            end
            else if (pend_q.size() == 0)
                pt_ch.valid <= 1'b0;
            else if (idle_draw())
            begin
                src_gap = $urandom_range(0, 15);
                pt_ch.valid <= 1'b0;
            end
            else
            begin
                pt_ch.valid      <= 1'b1;
                pt_ch.op         <= pend_q[0].op;
                pt_ch.pt_x       <= pend_q[0].x;
                pt_ch.pt_y       <= pend_q[0].y;
                pt_ch.pt_tag     <= pend_q[0].tag;
                pt_ch.read_index <= pend_q[0].idx;
            end
        end
    end

    // result channel ready: random bursts plus a few long holds
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt == 0 && press_idx < 2 &&
                pend_q.size() <= ((press_idx == 0) ? 1500 : 600))
            begin
                hold_cnt = HOLD_CYCLES;
                press_idx++;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                res_ch.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                res_ch.ready <= 1'b0;
            end
            else if (idle_draw())
            begin
                sink_gap = $urandom_range(0, 15);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // monitor: check results first, then predict for the accepted item
    always @(posedge clk or negedge rst_n)
    begin
        hull_res_t want;
        pt_cmd_t   c;
        if (!rst_n)
            pt_taken <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (hull_exp_q.size() == 0)
                begin
                    $display("%0t: result item with none expected, depth %0d", $time,
                             res_ch.hull_depth);
                    mismatches++;
                end
                else
                begin
                    want = hull_exp_q.pop_front();
                    cmp_field("hull_depth", COORD_W'(want.depth), COORD_W'(res_ch.hull_depth));
                    cmp_field("popped_count", COORD_W'(want.popped),
                              COORD_W'(res_ch.popped_count));
                    cmp_field("out_x", want.x, res_ch.out_x);
                    cmp_field("out_y", want.y, res_ch.out_y);
                    cmp_field("out_tag", COORD_W'(want.tag), COORD_W'(res_ch.out_tag));
                    cmp_field("overflow", COORD_W'(want.ovf), COORD_W'(res_ch.overflow));
                end
            end
            pt_taken <= pt_ch.valid && pt_ch.ready;
            if (pt_ch.valid && pt_ch.ready)
            begin
                c.op  = pt_ch.op;
                c.x   = pt_ch.pt_x;
                c.y   = pt_ch.pt_y;
                c.tag = pt_ch.pt_tag;
                c.idx = pt_ch.read_index;
                hull_exp_q.insert(hull_exp_q.size(), hull_apply(c));
            end
        end
    end

    // idle rate per stretch, and watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cyc <= cyc + 1;
            if (cyc % 256 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: idle_pct <= 0;
                    1: idle_pct <= 10;
                    default: idle_pct <= 30;
                endcase
            end
            if ((pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
        else
        begin
            cyc          <= 0;
            stall_cycles <= 0;
        end
    end

endmodule
